>>> src/mvm_pkg.sv
// Shared types and constants for the matrix-vector multiply-accumulate unit.
package mvm_pkg;

  localparam int MAX_COLUMNS_DEF = 256;
  localparam int OPND_W          = 64;
  localparam int SUM_W           = 128;
  localparam int COLS_W          = 9;
  localparam int ROWS_W          = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROWS = 2'd2;

  // Product and sum width selection
  typedef enum logic [1:0] {
    MODE_WRAP32  = 2'd0,
    MODE_WIDE64  = 2'd1,
    MODE_WRAP64  = 2'd2,
    MODE_WIDE128 = 2'd3
  } mode_t;

  // Per-element control that travels with the operands
  typedef struct packed {
    logic  last_col;
    logic  last_row;
    mode_t mode;
  } mac_ctrl_t;

endpackage

>>> src/mvm_mac.sv
// Pipelined multiply, product combine, row accumulator and result register.
module mvm_mac (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [mvm_pkg::OPND_W-1:0] in_a,
  input  logic [mvm_pkg::OPND_W-1:0] in_b,
  input  mvm_pkg::mac_ctrl_t        in_ctrl,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [mvm_pkg::SUM_W-1:0] out_tdata,  // sum_low [63:0], sum_high [127:64]
  output logic                      out_tlast   // final_row
);
  import mvm_pkg::*;

  // Partial product stage
  logic        p_valid_r;
  mac_ctrl_t   p_ctrl_r;
  logic [63:0] p00_r, p01_r, p10_r, p11_r;
  logic [31:0] a_lo, a_hi, b_lo, b_hi;

  // Product combine stage
  logic             s_valid_r;
  mac_ctrl_t        s_ctrl_r;
  logic [SUM_W-1:0] prod_r;
  logic [64:0]      mid;
  logic [SUM_W-1:0] prod_nxt;

  // Accumulator and result
  logic [SUM_W-1:0] acc_r;
  logic [SUM_W-1:0] acc_sum;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [63:0]      out_lo_r, out_hi_r;
  logic             out_last_r;

  logic acc_adv, s_ready, p_ready;

  // Hold a row-closing element until the result register is free
  assign acc_adv  = s_valid_r && (!s_ctrl_r.last_col || !out_valid_r || out_tready);
  assign s_ready  = !s_valid_r || acc_adv;
  assign p_ready  = !p_valid_r || s_ready;
  assign in_ready = p_ready;

  // Narrow modes use only the low 32 bits of both operands
  always_comb begin
    a_lo = in_a[31:0];
    b_lo = in_b[31:0];
    a_hi = in_a[63:32];
    b_hi = in_b[63:32];
    if (in_ctrl.mode == MODE_WRAP32 || in_ctrl.mode == MODE_WIDE64) begin
      a_hi = '0;
      b_hi = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (p_ready) begin
      p_valid_r <= in_valid;
    end
    if (p_ready && in_valid) begin
      p_ctrl_r <= in_ctrl;
      p00_r    <= 64'(a_lo) * 64'(b_lo);
      p01_r    <= 64'(a_lo) * 64'(b_hi);
      p10_r    <= 64'(a_hi) * 64'(b_lo);
      p11_r    <= 64'(a_hi) * 64'(b_hi);
    end
  end

  // Combine partial products: the outer terms abut, the middle terms add in
  always_comb begin
    mid      = {1'b0, p01_r} + {1'b0, p10_r};
    prod_nxt = {p11_r, p00_r} + {31'b0, mid, 32'b0};
    if (p_ctrl_r.mode == MODE_WRAP64) begin
      prod_nxt[SUM_W-1:64] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (s_ready) begin
      s_valid_r <= p_valid_r;
    end
    if (s_ready && p_valid_r) begin
      s_ctrl_r <= p_ctrl_r;
      prod_r   <= prod_nxt;
    end
  end

  assign acc_sum = acc_r + prod_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (acc_adv && s_ctrl_r.last_col) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Accumulate; at the end of a row truncate per mode and clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (acc_adv) begin
        acc_r <= s_ctrl_r.last_col ? '0 : acc_sum;
      end
    end
    if (acc_adv && s_ctrl_r.last_col) begin
      out_last_r <= s_ctrl_r.last_row;
      unique case (s_ctrl_r.mode)
        MODE_WRAP32: begin
          out_lo_r <= {32'b0, acc_sum[31:0]};
          out_hi_r <= '0;
        end
        MODE_WIDE64, MODE_WRAP64: begin
          out_lo_r <= acc_sum[63:0];
          out_hi_r <= '0;
        end
        MODE_WIDE128: begin
          out_lo_r <= acc_sum[63:0];
          out_hi_r <= acc_sum[SUM_W-1:64];
        end
        default: begin
          out_lo_r <= acc_sum[63:0];
          out_hi_r <= '0;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_hi_r, out_lo_r};
  assign out_tlast  = out_last_r;

endmodule

>>> src/matrix_vector_multiply_accumulate_unit.sv
// Top level of the unsigned integer matrix-vector multiply-accumulate unit.
// Beats with in_tuser low load the vector store in order; beats with in_tuser high are matrix
// elements in row-major order. One beat of either kind is taken every clock cycle while in_tready
// is high; the vector store has one write and one registered read port, and the product of each
// element is formed in a four-way 32x32 multiply stage, a combine stage and a 128-bit accumulate
// stage. The row sum passes through the operand, partial product, combine and result registers
// to out_tdata, with out_tlast marking the final row. A waiting result does not stop input until
// the three pipeline stages behind it are full, the first of them holding a row-closing element.
// Configuration may be written only while no element is in flight.
module matrix_vector_multiply_accumulate_unit #(
  parameter int MAX_COLUMNS = mvm_pkg::MAX_COLUMNS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [mvm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mvm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [mvm_pkg::OPND_W-1:0]     in_tdata,  // operand [63:0]
  input  logic                          in_tuser,  // func
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [mvm_pkg::SUM_W-1:0]      out_tdata, // sum_low [63:0], sum_high [127:64]
  output logic                          out_tlast  // final_row
);
  import mvm_pkg::*;

  localparam int CPOS_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CNT_W  = $clog2(MAX_COLUMNS + 1);
  localparam int CMP_W  = (CNT_W > COLS_W) ? CNT_W + 1 : COLS_W + 1;

  // Configuration
  mode_t              mode_r;
  logic [COLS_W-1:0]  cols_r;
  logic [ROWS_W-1:0]  rows_r;

  // Positions
  logic [CPOS_W-1:0]  col_pos_r, col_pos_nxt;
  logic [ROWS_W-1:0]  row_pos_r, row_pos_nxt;
  logic [CPOS_W-1:0]  load_pos_r, load_pos_nxt;
  logic [CPOS_W-1:0]  load_sel;
  logic [CMP_W-1:0]   load_inc;
  logic [CMP_W-1:0]   cols_ext, cols_eff;
  logic [ROWS_W-1:0]  rows_eff;
  logic               last_col, last_row;

  // Vector store
  logic [OPND_W-1:0]  vec_mem [MAX_COLUMNS];

  // Operand register feeding the multiplier
  logic               s1_valid_r;
  logic [OPND_W-1:0]  s1_a_r, s1_b_r;
  mac_ctrl_t          s1_ctrl_r;
  logic               mac_ready;
  logic               in_fire;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_WRAP32;
      cols_r <= COLS_W'(256);
      rows_r <= ROWS_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_IDX_MODE: mode_r <= mode_t'(cfg_wdata[1:0]);
        CFG_IDX_COLS: cols_r <= cfg_wdata[COLS_W-1:0];
        CFG_IDX_ROWS: rows_r <= cfg_wdata[ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the counts to their effective ranges
  always_comb begin
    cols_ext = CMP_W'(cols_r);
    if (cols_r == '0) begin
      cols_eff = CMP_W'(1);
    end else if (cols_ext > CMP_W'(MAX_COLUMNS)) begin
      cols_eff = CMP_W'(MAX_COLUMNS);
    end else begin
      cols_eff = cols_ext;
    end
    rows_eff = (rows_r == '0) ? ROWS_W'(1) : rows_r;
  end

  // Next positions
  always_comb begin
    last_col    = (CMP_W'(col_pos_r) + CMP_W'(1)) >= cols_eff;
    last_row    = ({1'b0, row_pos_r} + 17'd1) >= {1'b0, rows_eff};
    col_pos_nxt = last_col ? '0 : col_pos_r + CPOS_W'(1);
    row_pos_nxt = last_row ? '0 : row_pos_r + ROWS_W'(1);
    load_sel    = (CMP_W'(load_pos_r) < cols_eff) ? load_pos_r : '0;
    load_inc    = CMP_W'(load_sel) + CMP_W'(1);
    load_pos_nxt = (load_inc >= cols_eff) ? '0 : load_inc[CPOS_W-1:0];
  end

  assign in_tready = !s1_valid_r || mac_ready;
  assign in_fire   = in_tvalid && in_tready;

  // Advance positions on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r  <= '0;
      row_pos_r  <= '0;
      load_pos_r <= '0;
    end else if (in_fire) begin
      if (in_tuser) begin
        col_pos_r <= col_pos_nxt;
        if (last_col) begin
          row_pos_r <= row_pos_nxt;
        end
      end else begin
        load_pos_r <= load_pos_nxt;
      end
    end
  end

  // Vector store: write on load beats, registered read on matrix beats
  always_ff @(posedge clk) begin
    if (in_fire && !in_tuser) begin
      vec_mem[load_sel] <= in_tdata;
    end
    if (in_fire && in_tuser) begin
      s1_b_r <= vec_mem[col_pos_r];
    end
  end

  // Capture matrix elements for the multiplier
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_fire && in_tuser;
    end
    if (in_fire && in_tuser) begin
      s1_a_r             <= in_tdata;
      s1_ctrl_r.last_col <= last_col;
      s1_ctrl_r.last_row <= last_row;
      s1_ctrl_r.mode     <= mode_r;
    end
  end

  mvm_mac u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (s1_valid_r),
    .in_ready   (mac_ready),
    .in_a       (s1_a_r),
    .in_b       (s1_b_r),
    .in_ctrl    (s1_ctrl_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

>>> sim/mvm_row_sum_check.sv
// Row-sum predictor and comparator for the matrix-vector multiply-accumulate unit.
module mvm_row_sum_check #(
  parameter logic FUNC_MAC    = 1'b1,
  parameter int   MAX_COLUMNS = mvm_pkg::MAX_COLUMNS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [mvm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mvm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [mvm_pkg::OPND_W-1:0]     in_tdata,  // operand [63:0]
  input  logic                           in_tuser,  // func
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [mvm_pkg::SUM_W-1:0]      out_tdata, // sum_low [63:0], sum_high [127:64]
  input  logic                           out_tlast, // final_row
  output int                             mismatches,
  output int                             rows_pending,
  output int                             sums_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import mvm_pkg::*;

  typedef struct packed {
    logic [63:0] sum_high;
    logic [63:0] sum_low;
    logic        final_row;
  } row_sum_t;

  // Shadow of the block: vector store, accumulator, positions and registers
  logic [OPND_W-1:0] vec_mem [MAX_COLUMNS];
  logic [SUM_W-1:0]  acc;
  int                col_pos;
  int                row_pos;
  int                load_pos;
  mode_t             cur_mode;
  int                cur_cols;
  int                cur_rows;
  row_sum_t          sums_due [$];

  function automatic int span_cols();
    if (cur_cols == 0) return 1;
    if (cur_cols > MAX_COLUMNS) return MAX_COLUMNS;
    return cur_cols;
  endfunction

  // Form one element's product in the given precision, widened to the accumulator
  function automatic logic [SUM_W-1:0] element_product(mode_t m, logic [63:0] a,
                                                        logic [63:0] b);
    case (m)
      MODE_WRAP32, MODE_WIDE64: return {96'd0, a[31:0]} * {96'd0, b[31:0]};
      MODE_WRAP64:              return {64'd0, a * b};
      default:                  return {64'd0, a} * {64'd0, b};
    endcase
  endfunction

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    if (mismatches < 30)
      $display("MISMATCH %s at %0t ns: got %h, expected %h (row sum %0d)",
               field, $time, got, want, sums_seen);
    mismatches++;
  endtask

  // Absorb one accepted input beat; queue a row sum when it closes a row
  task automatic take_element(logic func, logic [63:0] value);
    int       cols;
    int       idx;
    row_sum_t s;
    cols = span_cols();
    if (func != FUNC_MAC) begin
      idx = (load_pos < cols) ? load_pos : 0;
      vec_mem[idx] = value;
      load_pos = (idx + 1 >= cols) ? 0 : idx + 1;
    end else begin
      idx = (col_pos < MAX_COLUMNS) ? col_pos : 0;
      acc = acc + element_product(cur_mode, value, vec_mem[idx]);
      if (col_pos + 1 < cols) begin
        col_pos++;
      end else begin
        s.final_row = (row_pos + 1 >= ((cur_rows == 0) ? 1 : cur_rows));
        s.sum_low   = acc[63:0];
        s.sum_high  = acc[127:64];
        if (cur_mode == MODE_WRAP32) begin
          s.sum_low[63:32] = '0;
          s.sum_high       = '0;
        end else if (cur_mode != MODE_WIDE128) begin
          s.sum_high = '0;
        end
        sums_due.push_back(s);
        acc     = '0;
        col_pos = 0;
        row_pos = s.final_row ? 0 : row_pos + 1;
      end
    end
  endtask

  // Compare one accepted output beat with the oldest pending row sum
  task automatic check_sum();
    row_sum_t want;
    if (sums_due.size() == 0) begin
      report("unexpected row sum, sum_low", out_tdata[63:0], '0);
    end else begin
      want = sums_due.pop_front();
      if (out_tdata[63:0] !== want.sum_low) report("sum_low", out_tdata[63:0], want.sum_low);
      if (out_tdata[127:64] !== want.sum_high)
        report("sum_high", out_tdata[127:64], want.sum_high);
      if (out_tlast !== want.final_row)
        report("final_row", 64'(out_tlast), 64'(want.final_row));
    end
    sums_seen++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      acc        = '0;
      col_pos    = 0;
      row_pos    = 0;
      load_pos   = 0;
      cur_mode   = MODE_WRAP32;
      cur_cols   = 256;
      cur_rows   = 1;
      mismatches = 0;
      sums_seen  = 0;
      sums_due.delete();
    end else begin
      // Drain first: a result leaving now never stems from a beat entering now
      if (out_tvalid && out_tready) check_sum();
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_IDX_MODE: cur_mode = mode_t'(cfg_wdata[1:0]);
          CFG_IDX_COLS: cur_cols = int'(cfg_wdata[8:0]);
          CFG_IDX_ROWS: cur_rows = int'(cfg_wdata[15:0]);
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) take_element(in_tuser, in_tdata);
    end
    rows_pending <= sums_due.size();
  end

endmodule

>>> sim/matrix_vector_multiply_accumulate_unit_tb.sv
// Stimulus, clocking and verdict for the matrix-vector multiply-accumulate unit.
module matrix_vector_multiply_accumulate_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mvm_pkg::*;

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_MAC     = 1'b1;
  localparam int   DRAIN_CYCLES = 8;
  localparam int   CYCLE_LIMIT  = 500000;
  localparam int   RANDOM_BEATS = 150;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [OPND_W-1:0]     in_tdata   = '0;  // operand [63:0]
  logic                  in_tuser   = 1'b0; // func
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [SUM_W-1:0]      out_tdata;         // sum_low [63:0], sum_high [127:64]
  logic                  out_tlast;         // final_row

  int mismatches;
  int rows_pending;
  int sums_seen;
  int cycle_cnt   = 0;
  int beats_sent  = 0;
  int mac_beats   = 0;
  int settings    = 0;
  int burst_left  = 0;
  int rx_left     = 0;
  int span_cols   = 256;
  int span_rows   = 1;
  bit steady      = 1'b0;

  matrix_vector_multiply_accumulate_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  mvm_row_sum_check #(.FUNC_MAC(FUNC_MAC)) u_row_sum_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .mismatches   (mismatches),
    .rows_pending (rows_pending),
    .sums_seen    (sums_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d row sums pending", cycle_cnt, rows_pending);
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: alternate ready and stall runs, with occasional long stall and long ready stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_left    <= 0;
    end else if (rx_left == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          out_tready <= 1'b1;
          rx_left    <= $urandom_range(1, 20);
        end
        5, 6, 7: begin
          out_tready <= 1'b0;
          rx_left    <= $urandom_range(1, 6);
        end
        8: begin
          out_tready <= 1'b0;
          rx_left    <= $urandom_range(10, 30);
        end
        default: begin
          out_tready <= 1'b1;
          rx_left    <= $urandom_range(60, 150);
        end
      endcase
    end else begin
      rx_left <= rx_left - 1;
    end
  end

  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 64'hFFFF_FFFF_0000_0000;
      3:       return 64'h0000_0000_FFFF_FFFF;
      4:       return 64'($urandom_range(0, 15));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Offer one beat; open a new burst after a random gap when the last one ran out
  task automatic send_beat(logic func, logic [63:0] value);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    beats_sent++;
    if (func == FUNC_MAC) mac_beats++;
  endtask

  // Hold input low until every row sum is out, then let the pipeline empty
  task automatic settle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (rows_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(mode_t mode, int cols, int rows);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_IDX_MODE;
    cfg_wdata <= CFG_DATA_W'(mode);
    @(posedge clk);
    cfg_index <= CFG_IDX_COLS;
    cfg_wdata <= CFG_DATA_W'(cols);
    @(posedge clk);
    cfg_index <= CFG_IDX_ROWS;
    cfg_wdata <= CFG_DATA_W'(rows);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    span_cols = (cols == 0) ? 1 : ((cols > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : cols);
    span_rows = (rows == 0) ? 1 : rows;
    settings++;
  endtask

  // Load a vector, then stream whole rows; optionally sprinkle stray loads in between
  task automatic stream_matrix(int n_rows, bit with_loads, bit noisy);
    if (with_loads)
      for (int i = 0; i < span_cols; i++) send_beat(FUNC_LOAD, pick_operand());
    for (int r = 0; r < n_rows; r++)
      for (int c = 0; c < span_cols; c++) begin
        if (noisy && $urandom_range(0, 11) == 0) send_beat(FUNC_LOAD, pick_operand());
        send_beat(FUNC_MAC, pick_operand());
      end
  endtask

  initial begin
    int    rand_start;
    int    ncols;
    int    nrows;
    mode_t mode;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Oversized column count clamps to the widest row: fill the whole vector store
    // so no later read finds an empty entry, then run one full-width row
    configure(mode_t'($urandom_range(0, 3)), 511, 2);
    stream_matrix(1, 1'b1, 1'b0);
    settle();

    // Full-scale operands in each precision, one column, two rows
    steady = 1'b1;
    for (int m = 0; m < 4; m++) begin
      configure(mode_t'(m), 1, 2);
      send_beat(FUNC_LOAD, '1);
      send_beat(FUNC_MAC, '1);
      send_beat(FUNC_MAC, '1);
      settle();
    end

    // Zero column and row counts act as one
    configure(MODE_WIDE64, 0, 0);
    send_beat(FUNC_LOAD, 64'hFFFF_FFFF_FFFF_FFFE);
    send_beat(FUNC_MAC, '1);
    send_beat(FUNC_MAC, 64'h8000_0000_8000_0001);
    settle();

    // Switch precision in the middle of a row
    configure(MODE_WIDE128, 2, 1);
    send_beat(FUNC_MAC, '1);
    settle();
    configure(MODE_WIDE64, 2, 1);
    send_beat(FUNC_MAC, '1);
    settle();

    // Shrink the column count below the column in progress
    configure(MODE_WRAP64, 4, 3);
    send_beat(FUNC_MAC, '1);
    send_beat(FUNC_MAC, pick_operand());
    settle();
    configure(MODE_WRAP64, 2, 3);
    send_beat(FUNC_MAC, '1);
    settle();

    // Largest row count, then shrink it below the row in progress
    configure(MODE_WRAP32, 1, 65535);
    repeat (3) send_beat(FUNC_MAC, '1);
    settle();
    configure(MODE_WRAP32, 1, 2);
    send_beat(FUNC_MAC, '1);
    settle();

    // Random phases: mostly whole matrices, some broken rows and plain noise
    rand_start = beats_sent;
    while (beats_sent - rand_start < RANDOM_BEATS) begin
      mode = mode_t'($urandom_range(0, 3));
      case ($urandom_range(0, 19))
        0:       ncols = 0;
        1, 2, 3: ncols = $urandom_range(9, 24);
        default: ncols = $urandom_range(1, 4);
      endcase
      case ($urandom_range(0, 9))
        0:       nrows = 0;
        1:       nrows = 65535;
        2:       nrows = $urandom_range(5, 65535);
        default: nrows = $urandom_range(1, 4);
      endcase
      configure(mode, ncols, nrows);
      steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        7, 8: begin
          stream_matrix($urandom_range(1, (span_rows < 3) ? span_rows : 3), 1'b1, 1'b1);
          repeat ($urandom_range(0, span_cols - 1)) send_beat(FUNC_MAC, pick_operand());
          repeat ($urandom_range(0, 2)) send_beat(FUNC_LOAD, pick_operand());
        end
        9: begin
          repeat ($urandom_range(1, 12))
            send_beat($urandom_range(0, 1) ? FUNC_MAC : FUNC_LOAD, pick_operand());
        end
        default: begin
          stream_matrix($urandom_range(1, (span_rows < 4) ? span_rows : 4), 1'b1, 1'b0);
        end
      endcase
      settle();
    end

    $display("Run covered %0d input beats (%0d matrix elements) over %0d register settings",
             beats_sent, mac_beats, settings);
    $display("%0d row sums compared, %0d mismatches, %0d left pending",
             sums_seen, mismatches, rows_pending);
    if (mismatches == 0 && rows_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
